@@ src/adv_data_tlv_parser_assert.svh @@
// Assertion macros shared by the advertising-data parser modules.
// Each module that uses them has ports named clk and rst_n.
`ifndef ADV_DATA_TLV_PARSER_ASSERT_SVH
`define ADV_DATA_TLV_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ADP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/adp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_pkg
// Types, codes and helpers of the advertising-data TLV parser.
// ----------------------------------------------------------------------------
package adp_pkg;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_PAY
  } phase_t;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_NONE   = 3'd0;
  localparam kind_t KIND_FLAGS  = 3'd1;
  localparam kind_t KIND_TX     = 3'd2;
  localparam kind_t KIND_APPEAR = 3'd3;
  localparam kind_t KIND_SHORT  = 3'd4;
  localparam kind_t KIND_FULL   = 3'd5;
  localparam kind_t KIND_MFT    = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  localparam logic [7:0] AD_TYPE_FLAGS  = 8'h01;
  localparam logic [7:0] AD_TYPE_TX     = 8'h0A;
  localparam logic [7:0] AD_TYPE_APPEAR = 8'h19;
  localparam logic [7:0] AD_TYPE_SHORT  = 8'h08;
  localparam logic [7:0] AD_TYPE_FULL   = 8'h09;
  localparam logic [7:0] AD_TYPE_MFT    = 8'hFF;

  localparam int MASK_W = 6;
  localparam logic [MASK_W-1:0] MASK_RST = 6'h3F;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic [7:0]  offset;
    logic        gend;
    logic        done;
    status_t     status;
  } adp_res_t;

  function automatic kind_t kind_of_type(input logic [7:0] t);
    kind_t k;
    case (t)
      AD_TYPE_FLAGS:  k = KIND_FLAGS;
      AD_TYPE_TX:     k = KIND_TX;
      AD_TYPE_APPEAR: k = KIND_APPEAR;
      AD_TYPE_SHORT:  k = KIND_SHORT;
      AD_TYPE_FULL:   k = KIND_FULL;
      AD_TYPE_MFT:    k = KIND_MFT;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

@@ src/adp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_front
// Byte parser: walks the length/type/payload groups and builds one result
// record per reported field and per buffer end.
// ----------------------------------------------------------------------------
`include "adv_data_tlv_parser_assert.svh"

module adp_front
  import adp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [MASK_W-1:0] cfg_data,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              push,
  output adp_res_t          push_res
);

  logic [MASK_W-1:0] mask_r;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        remaining_r, remaining_nxt;
  kind_t             kind_r, kind_nxt;
  logic [7:0]        offset_r, offset_nxt;
  logic [7:0]        app_low_r, app_low_nxt;
  status_t           err_r, err_nxt;
  logic              first_r, first_nxt;
  logic              stopped_r, stopped_nxt;

  logic       emit;
  logic       enabled;
  logic       fin;
  logic [7:0] rem_m1;
  kind_t      type_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RST;
    end else if (cfg_valid) begin
      mask_r <= cfg_data;
    end
  end

  assign rem_m1    = remaining_r - 8'd1;
  assign type_kind = kind_of_type(data_byte);

  always_comb begin
    case (kind_r)
      KIND_FLAGS:  enabled = mask_r[0];
      KIND_TX:     enabled = mask_r[1];
      KIND_APPEAR: enabled = mask_r[2];
      KIND_SHORT:  enabled = mask_r[3];
      KIND_FULL:   enabled = mask_r[4];
      KIND_MFT:    enabled = mask_r[5];
      default:     enabled = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    kind_nxt      = kind_r;
    offset_nxt    = offset_r;
    app_low_nxt   = app_low_r;
    err_nxt       = err_r;
    first_nxt     = first_r;
    stopped_nxt   = stopped_r;
    emit          = 1'b0;
    fin           = 1'b0;
    push_res      = '0;

    if (!stopped_r) begin
      case (phase_r)
        PH_LEN: begin
          if (data_byte == 8'd0) begin
            err_nxt     = first_r ? ST_EMPTY : ST_OK;
            stopped_nxt = 1'b1;
          end else begin
            remaining_nxt = data_byte;
            phase_nxt     = PH_TYPE;
          end
          first_nxt = 1'b0;
        end
        PH_TYPE: begin
          if (type_kind == KIND_NONE) begin
            err_nxt     = ST_BAD;
            stopped_nxt = 1'b1;
          end else begin
            kind_nxt      = type_kind;
            remaining_nxt = rem_m1;
            offset_nxt    = 8'd0;
            phase_nxt     = (rem_m1 != 8'd0) ? PH_PAY : PH_LEN;
          end
        end
        PH_PAY: begin
          remaining_nxt = rem_m1;
          fin           = (rem_m1 == 8'd0);
          if (enabled) begin
            case (kind_r)
              KIND_FLAGS, KIND_TX: begin
                emit           = (offset_r == 8'd0);
                push_res.value = {8'd0, data_byte};
              end
              KIND_APPEAR: begin
                if (offset_r == 8'd0) begin
                  app_low_nxt = data_byte;
                end else if (offset_r == 8'd1) begin
                  emit           = 1'b1;
                  push_res.value = {data_byte, app_low_r};
                end
              end
              default: begin
                emit           = 1'b1;
                push_res.value = {8'd0, data_byte};
              end
            endcase
          end
          offset_nxt = offset_r + 8'd1;
          if (fin) begin
            phase_nxt = PH_LEN;
          end
        end
        default: begin
          phase_nxt = PH_LEN;
        end
      endcase
    end

    if (emit) begin
      push_res.kind   = kind_r;
      push_res.offset = offset_r;
      push_res.gend   = fin;
    end

    if (last_byte) begin
      // buffer ended inside a group: drop the field and flag it
      if (!stopped_nxt && phase_nxt != PH_LEN) begin
        err_nxt  = ST_BAD;
        push_res = '0;
      end
      push_res.done   = 1'b1;
      push_res.status = err_nxt;
      phase_nxt       = PH_LEN;
      remaining_nxt   = 8'd0;
      kind_nxt        = KIND_NONE;
      offset_nxt      = 8'd0;
      app_low_nxt     = 8'd0;
      err_nxt         = ST_OK;
      first_nxt       = 1'b1;
      stopped_nxt     = 1'b0;
    end
  end

  assign push = accept && (emit || last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      remaining_r <= 8'd0;
      kind_r      <= KIND_NONE;
      offset_r    <= 8'd0;
      app_low_r   <= 8'd0;
      err_r       <= ST_OK;
      first_r     <= 1'b1;
      stopped_r   <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      kind_r      <= kind_nxt;
      offset_r    <= offset_nxt;
      app_low_r   <= app_low_nxt;
      err_r       <= err_nxt;
      first_r     <= first_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  `ADP_ASSERT_IMP(a_field_has_kind, push && !push_res.done, push_res.kind != KIND_NONE, "field result without kind")
  `ADP_ASSERT_NXT(a_stop_holds, accept && stopped_r && !last_byte, stopped_r, "parser left stop before buffer end")
  `ADP_ASSERT_IMP(a_pay_has_length, phase_r == PH_PAY && !stopped_r, remaining_r != 8'd0, "payload phase with nothing left")

endmodule

@@ src/adp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "adv_data_tlv_parser_assert.svh"

module adp_fifo
  import adp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  adp_res_t push_res,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output adp_res_t head_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  adp_res_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_res   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `ADP_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into full queue")
  `ADP_ASSERT_IMP(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

@@ src/adp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_back
// Output stage: takes queued results into the output register and drives
// the result stream.
// ----------------------------------------------------------------------------
`include "adv_data_tlv_parser_assert.svh"

module adp_back
  import adp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  adp_res_t               head_res,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [7:0]             out_tuser
);

  logic     valid_r;
  adp_res_t res_r;

  // refill whenever the register is empty or its beat is taken
  assign pop = head_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, res_r.status, res_r.gend, res_r.offset, res_r.value};
  assign out_tlast  = res_r.done;
  assign out_tuser  = {5'd0, res_r.kind};

  `ADP_ASSERT_NXT(a_pop_loads, pop, out_tvalid, "popped result not presented")

endmodule

@@ src/adv_data_tlv_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adv_data_tlv_parser
// Advertising-data length/type/value parser, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one buffer byte per beat, in_tlast on the final byte of a buffer.
//   out_* : one beat per reported field or buffer end (a field on the final byte
//           shares its beat); buffer ends have out_tlast high, parse status in tdata.
//   cfg_* : writes the 6-bit type enable mask; write only while idle.
// Path: a result goes into the result queue, then into the output register behind out_tvalid.
// Throughput: one byte per cycle while the queue is not full; the parser state
//   updates once per accepted byte, and the result queue plus output register
//   let input flow on while the receiver holds a beat.
// When the receiver stalls, results collect in the queue (QUEUE_DEPTH deep);
//   in_tready drops once it is full, and rises again as beats are taken.
// Reset: parser returns to expect a length byte, mask goes to all types
//   enabled, queue and output register are emptied.
// ----------------------------------------------------------------------------
module adv_data_tlv_parser
  import adp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] field_value, [23:16] payload_offset,
                                             // [24] group_end, [26:25] parse_status
  output logic                   out_tlast,  // done_res
  output logic [7:0]             out_tuser,  // [2:0] field_kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MASK_W-1:0]      cfg_data
);

  logic     accept;
  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;
  adp_res_t push_res;
  adp_res_t head_res;

  assign in_tready = !full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  adp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push),
    .push_res  (push_res)
  );

  adp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (push_res),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_res   (head_res)
  );

  adp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_res   (head_res),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
